[rtl/core/rv64ic_instruction_decoder_macros.svh]
// ----------------------------------------------------------------------------
// RV64IC decoder assertion macros
// Concurrent check helpers shared by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef RV64IC_INSTRUCTION_DECODER_MACROS_SVH
`define RV64IC_INSTRUCTION_DECODER_MACROS_SVH

// same-cycle implication, disabled in reset
`define RVD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rv64ic decoder check failed");

// next-cycle implication, disabled in reset
`define RVD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rv64ic decoder check failed");

`endif

[rtl/core/rvdec_pkg.sv]
// ----------------------------------------------------------------------------
// RV64IC decoder package
// Mnemonic and format codes, opcodes, decode result type and lookup tables.
// ----------------------------------------------------------------------------
package rvdec_pkg;

    typedef logic [5:0] t_mnem;
    typedef logic [2:0] t_fmt;
    typedef logic [4:0] t_reg;

    localparam t_mnem M_UNK    = 6'd0;
    localparam t_mnem M_LUI    = 6'd1;
    localparam t_mnem M_AUIPC  = 6'd2;
    localparam t_mnem M_JAL    = 6'd3;
    localparam t_mnem M_JALR   = 6'd4;
    localparam t_mnem M_BEQ    = 6'd5;
    localparam t_mnem M_BNE    = 6'd6;
    localparam t_mnem M_BLT    = 6'd7;
    localparam t_mnem M_BGE    = 6'd8;
    localparam t_mnem M_BLTU   = 6'd9;
    localparam t_mnem M_BGEU   = 6'd10;
    localparam t_mnem M_LB     = 6'd11;
    localparam t_mnem M_LH     = 6'd12;
    localparam t_mnem M_LW     = 6'd13;
    localparam t_mnem M_LD     = 6'd14;
    localparam t_mnem M_LBU    = 6'd15;
    localparam t_mnem M_LHU    = 6'd16;
    localparam t_mnem M_LWU    = 6'd17;
    localparam t_mnem M_SB     = 6'd18;
    localparam t_mnem M_SH     = 6'd19;
    localparam t_mnem M_SW     = 6'd20;
    localparam t_mnem M_SD     = 6'd21;
    localparam t_mnem M_ADDI   = 6'd22;
    localparam t_mnem M_SLTI   = 6'd23;
    localparam t_mnem M_SLTIU  = 6'd24;
    localparam t_mnem M_XORI   = 6'd25;
    localparam t_mnem M_ORI    = 6'd26;
    localparam t_mnem M_ANDI   = 6'd27;
    localparam t_mnem M_SLLI   = 6'd28;
    localparam t_mnem M_SRLI   = 6'd29;
    localparam t_mnem M_SRAI   = 6'd30;
    localparam t_mnem M_ADD    = 6'd31;
    localparam t_mnem M_SUB    = 6'd32;
    localparam t_mnem M_SLL    = 6'd33;
    localparam t_mnem M_SLT    = 6'd34;
    localparam t_mnem M_SLTU   = 6'd35;
    localparam t_mnem M_XOR    = 6'd36;
    localparam t_mnem M_SRL    = 6'd37;
    localparam t_mnem M_SRA    = 6'd38;
    localparam t_mnem M_OR     = 6'd39;
    localparam t_mnem M_AND    = 6'd40;
    localparam t_mnem M_EBREAK = 6'd41;
    localparam t_mnem M_ECALL  = 6'd42;
    localparam t_mnem M_ADDIW  = 6'd43;
    localparam t_mnem M_SLLIW  = 6'd44;
    localparam t_mnem M_SRLIW  = 6'd45;
    localparam t_mnem M_SRAIW  = 6'd46;
    localparam t_mnem M_ADDW   = 6'd47;
    localparam t_mnem M_SUBW   = 6'd48;
    localparam t_mnem M_SLLW   = 6'd49;
    localparam t_mnem M_SRLW   = 6'd50;
    localparam t_mnem M_SRAW   = 6'd51;

    localparam t_fmt F_SP = 3'd0;
    localparam t_fmt F_R  = 3'd1;
    localparam t_fmt F_I  = 3'd2;
    localparam t_fmt F_S  = 3'd3;
    localparam t_fmt F_B  = 3'd4;
    localparam t_fmt F_U  = 3'd5;
    localparam t_fmt F_J  = 3'd6;

    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_REG32  = 7'b0111011;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_IMM32  = 7'b0011011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_SYSTEM = 7'b1110011;

    localparam logic [31:0] W_ECALL  = 32'h0000_0073;
    localparam logic [31:0] W_EBREAK = 32'h0010_0073;

    localparam logic [1:0] Q_FULL = 2'b11;

    localparam logic [2:0] LEN_SHORT = 3'd2;
    localparam logic [2:0] LEN_FULL  = 3'd4;

    localparam logic [6:0] F7_ZERO = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    typedef struct packed {
        t_mnem       mnem;
        t_fmt        fmt;
        t_reg        rd;
        t_reg        rs1;
        t_reg        rs2;
        logic [31:0] imm;
    } t_dec;

    function automatic t_mnem f_branch(input logic [2:0] f3);
        t_mnem m;
        unique case (f3)
            3'd0: m = M_BEQ;
            3'd1: m = M_BNE;
            3'd4: m = M_BLT;
            3'd5: m = M_BGE;
            3'd6: m = M_BLTU;
            3'd7: m = M_BGEU;
            default: m = M_UNK;
        endcase
        return m;
    endfunction

    function automatic t_mnem f_load(input logic [2:0] f3);
        t_mnem m;
        unique case (f3)
            3'd0: m = M_LB;
            3'd1: m = M_LH;
            3'd2: m = M_LW;
            3'd3: m = M_LD;
            3'd4: m = M_LBU;
            3'd5: m = M_LHU;
            3'd6: m = M_LWU;
            default: m = M_UNK;
        endcase
        return m;
    endfunction

    function automatic t_mnem f_store(input logic [2:0] f3);
        t_mnem m;
        unique case (f3)
            3'd0: m = M_SB;
            3'd1: m = M_SH;
            3'd2: m = M_SW;
            3'd3: m = M_SD;
            default: m = M_UNK;
        endcase
        return m;
    endfunction

    function automatic t_mnem f_opimm(input logic [2:0] f3);
        t_mnem m;
        unique case (f3)
            3'd0: m = M_ADDI;
            3'd2: m = M_SLTI;
            3'd3: m = M_SLTIU;
            3'd4: m = M_XORI;
            3'd6: m = M_ORI;
            3'd7: m = M_ANDI;
            default: m = M_UNK;
        endcase
        return m;
    endfunction

    function automatic t_mnem f_op(input logic [2:0] f3);
        t_mnem m;
        unique case (f3)
            3'd0: m = M_ADD;
            3'd1: m = M_SLL;
            3'd2: m = M_SLT;
            3'd3: m = M_SLTU;
            3'd4: m = M_XOR;
            3'd5: m = M_SRL;
            3'd6: m = M_OR;
            default: m = M_AND;
        endcase
        return m;
    endfunction

    function automatic t_mnem f_calu(input logic [2:0] sel);
        t_mnem m;
        unique case (sel)
            3'd0: m = M_SUB;
            3'd1: m = M_XOR;
            3'd2: m = M_OR;
            3'd3: m = M_AND;
            3'd4: m = M_SUBW;
            3'd5: m = M_ADDW;
            default: m = M_UNK;
        endcase
        return m;
    endfunction

endpackage

[rtl/core/rv64ic_instruction_decoder.sv]
// ----------------------------------------------------------------------------
// RV64IC instruction decoder
// Input register, then decode into the result register.
// Throughput one request per cycle while i_m_tready is high, limited by the single decode stage.
// Synchronous active-low reset clears both stage valid flags only.
// ----------------------------------------------------------------------------
`include "rv64ic_instruction_decoder_macros.svh"

module rv64ic_instruction_decoder import rvdec_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] instr_word
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] known, [6:1] mnemonic, [9:7] format, [14:10] dest_reg,
    // [19:15] src1_reg, [24:20] src2_reg, [56:25] immediate,
    // [59:57] length_bytes, [63:60] zero
    output logic [63:0] o_m_tdata
);

    logic        r_v1;
    logic        n_v1;
    logic [31:0] r_instr;
    logic        r_v2;
    logic        n_v2;
    t_dec        r_dec;
    t_dec        n_dec;
    logic [2:0]  r_len;
    logic [2:0]  n_len;

    logic        s1_adv;
    t_dec        dec_full;
    t_dec        dec_short;
    t_dec        dec_sel;

    rvdec_full u_full (
        .i_word (r_instr),
        .o_dec  (dec_full)
    );

    rvdec_short u_short (
        .i_half (r_instr[15:0]),
        .o_dec  (dec_short)
    );

    assign s1_adv     = !r_v2 || i_m_tready;
    assign o_s_tready = !r_v1 || s1_adv;

    always_comb begin
        dec_sel = (r_instr[1:0] == Q_FULL) ? dec_full : dec_short;
        n_len   = (r_instr[1:0] == Q_FULL) ? LEN_FULL : LEN_SHORT;
        n_dec   = (dec_sel.mnem == M_UNK) ? '0 : dec_sel;
        n_v1    = o_s_tready ? i_s_tvalid : r_v1;
        n_v2    = s1_adv ? r_v1 : r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_instr <= i_s_tdata;
        end
        if (s1_adv && r_v1) begin
            r_dec <= n_dec;
            r_len <= n_len;
        end
    end

    assign o_m_tvalid = r_v2;
    assign o_m_tdata  = {4'd0, r_len, r_dec.imm, r_dec.rs2, r_dec.rs1, r_dec.rd,
                         r_dec.fmt, r_dec.mnem, (r_dec.mnem != M_UNK)};

    `RVD_ASSERT_NEXT(a_in_to_s1, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_v1)
    `RVD_ASSERT_NEXT(a_s1_to_out, i_clk, i_rst_n, r_v1 && s1_adv, r_v2)
    `RVD_ASSERT_SAME(a_unknown_clear, i_clk, i_rst_n, r_v2 && r_dec.mnem == M_UNK,
                     r_dec.imm == 32'd0 && r_dec.rd == 5'd0 && r_dec.fmt == F_SP)
    `RVD_ASSERT_SAME(a_len_legal, i_clk, i_rst_n, r_v2,
                     r_len == LEN_SHORT || r_len == LEN_FULL)

endmodule

[rtl/core/rvdec_full.sv]
// ----------------------------------------------------------------------------
// RV64I full-length decode
// Decodes a 32-bit base instruction into mnemonic, format, registers, imm.
// ----------------------------------------------------------------------------
module rvdec_full import rvdec_pkg::*; (
    input  logic [31:0] i_word,
    output t_dec        o_dec
);

    logic [2:0]  f3;
    logic [6:0]  f7;
    t_reg        rd;
    t_reg        rs1;
    t_reg        rs2;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;

    assign f3    = i_word[14:12];
    assign f7    = i_word[31:25];
    assign rd    = i_word[11:7];
    assign rs1   = i_word[19:15];
    assign rs2   = i_word[24:20];
    assign imm_i = {{20{i_word[31]}}, i_word[31:20]};
    assign imm_s = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
    assign imm_b = {{19{i_word[31]}}, i_word[31], i_word[7], i_word[30:25],
                    i_word[11:8], 1'b0};
    assign imm_j = {{11{i_word[31]}}, i_word[31], i_word[19:12], i_word[20],
                    i_word[30:21], 1'b0};
    assign imm_u = {i_word[31:12], 12'b0};

    always_comb begin
        o_dec = '0;
        unique case (i_word[6:0])
            OP_LUI: begin
                o_dec = '{M_LUI, F_U, rd, 5'd0, 5'd0, imm_u};
            end
            OP_AUIPC: begin
                o_dec = '{M_AUIPC, F_U, rd, 5'd0, 5'd0, imm_u};
            end
            OP_JAL: begin
                o_dec = '{M_JAL, F_J, rd, 5'd0, 5'd0, imm_j};
            end
            OP_JALR: begin
                o_dec = '{(f3 == 3'd0) ? M_JALR : M_UNK, F_I, rd, rs1, 5'd0, imm_i};
            end
            OP_BRANCH: begin
                o_dec = '{f_branch(f3), F_B, 5'd0, rs1, rs2, imm_b};
            end
            OP_LOAD: begin
                o_dec = '{f_load(f3), F_I, rd, rs1, 5'd0, imm_i};
            end
            OP_STORE: begin
                o_dec = '{f_store(f3), F_S, 5'd0, rs1, rs2, imm_s};
            end
            OP_IMM: begin
                o_dec = '{f_opimm(f3), F_I, rd, rs1, 5'd0, imm_i};
                if (f3 == 3'd1) begin
                    o_dec.mnem = (i_word[31:26] == 6'd0) ? M_SLLI : M_UNK;
                    o_dec.imm  = {26'd0, i_word[25:20]};
                end else if (f3 == 3'd5) begin
                    o_dec.mnem = (i_word[31:26] == 6'd0)   ? M_SRLI :
                                 (i_word[31:26] == 6'h10) ? M_SRAI : M_UNK;
                    o_dec.imm  = {26'd0, i_word[25:20]};
                end
            end
            OP_IMM32: begin
                o_dec = '{M_UNK, F_I, rd, rs1, 5'd0, {27'd0, i_word[24:20]}};
                if (f3 == 3'd0) begin
                    o_dec.mnem = M_ADDIW;
                    o_dec.imm  = imm_i;
                end else if (f3 == 3'd1 && f7 == F7_ZERO) begin
                    o_dec.mnem = M_SLLIW;
                end else if (f3 == 3'd5 && f7 == F7_ZERO) begin
                    o_dec.mnem = M_SRLIW;
                end else if (f3 == 3'd5 && f7 == F7_ALT) begin
                    o_dec.mnem = M_SRAIW;
                end
            end
            OP_REG: begin
                o_dec = '{M_UNK, F_R, rd, rs1, rs2, 32'd0};
                if (f7 == F7_ZERO) begin
                    o_dec.mnem = f_op(f3);
                end else if (f7 == F7_ALT && f3 == 3'd0) begin
                    o_dec.mnem = M_SUB;
                end else if (f7 == F7_ALT && f3 == 3'd5) begin
                    o_dec.mnem = M_SRA;
                end
            end
            OP_REG32: begin
                o_dec = '{M_UNK, F_R, rd, rs1, rs2, 32'd0};
                if (f7 == F7_ZERO && f3 == 3'd0) begin
                    o_dec.mnem = M_ADDW;
                end else if (f7 == F7_ZERO && f3 == 3'd1) begin
                    o_dec.mnem = M_SLLW;
                end else if (f7 == F7_ZERO && f3 == 3'd5) begin
                    o_dec.mnem = M_SRLW;
                end else if (f7 == F7_ALT && f3 == 3'd0) begin
                    o_dec.mnem = M_SUBW;
                end else if (f7 == F7_ALT && f3 == 3'd5) begin
                    o_dec.mnem = M_SRAW;
                end
            end
            OP_SYSTEM: begin
                if (i_word == W_ECALL) begin
                    o_dec.mnem = M_ECALL;
                end else if (i_word == W_EBREAK) begin
                    o_dec.mnem = M_EBREAK;
                end
            end
            default: begin
                o_dec = '0;
            end
        endcase
    end

endmodule

[rtl/core/rvdec_short.sv]
// ----------------------------------------------------------------------------
// RVC compressed decode
// Expands a 16-bit compressed instruction to its RV64I equivalent fields.
// ----------------------------------------------------------------------------
module rvdec_short import rvdec_pkg::*; (
    input  logic [15:0] i_half,
    output t_dec        o_dec
);

    // {quadrant, funct3}
    localparam logic [4:0] C_ADDI4SPN = 5'b00_000;
    localparam logic [4:0] C_LW       = 5'b00_010;
    localparam logic [4:0] C_LD       = 5'b00_011;
    localparam logic [4:0] C_SW       = 5'b00_110;
    localparam logic [4:0] C_SD       = 5'b00_111;
    localparam logic [4:0] C_ADDI     = 5'b01_000;
    localparam logic [4:0] C_ADDIW    = 5'b01_001;
    localparam logic [4:0] C_LI       = 5'b01_010;
    localparam logic [4:0] C_LUI      = 5'b01_011;
    localparam logic [4:0] C_MISC_ALU = 5'b01_100;
    localparam logic [4:0] C_J        = 5'b01_101;
    localparam logic [4:0] C_BEQZ     = 5'b01_110;
    localparam logic [4:0] C_BNEZ     = 5'b01_111;
    localparam logic [4:0] C_SLLI     = 5'b10_000;
    localparam logic [4:0] C_LWSP     = 5'b10_010;
    localparam logic [4:0] C_LDSP     = 5'b10_011;
    localparam logic [4:0] C_JR_MV    = 5'b10_100;
    localparam logic [4:0] C_SWSP     = 5'b10_110;
    localparam logic [4:0] C_SDSP     = 5'b10_111;

    localparam t_reg R_ZERO = 5'd0;
    localparam t_reg R_RA   = 5'd1;
    localparam t_reg R_SP   = 5'd2;

    logic [4:0]  sel;
    logic        b12;
    t_reg        r5;
    t_reg        s5;
    t_reg        rp7;
    t_reg        rp2;
    logic [31:0] imm6;
    logic [31:0] sh;
    logic [9:0]  u_4spn;
    logic [6:0]  u_lw;
    logic [7:0]  u_ld;
    logic [9:0]  u_16sp;
    logic [11:0] u_j;
    logic [8:0]  u_b;
    logic [7:0]  u_lwsp;
    logic [8:0]  u_ldsp;
    logic [7:0]  u_swsp;
    logic [8:0]  u_sdsp;

    assign sel   = {i_half[1:0], i_half[15:13]};
    assign b12   = i_half[12];
    assign r5    = i_half[11:7];
    assign s5    = i_half[6:2];
    assign rp7   = {2'b01, i_half[9:7]};
    assign rp2   = {2'b01, i_half[4:2]};
    assign imm6  = {{27{b12}}, s5};
    assign sh    = {26'd0, b12, s5};

    assign u_4spn = {i_half[10:7], i_half[12:11], i_half[5], i_half[6], 2'b00};
    assign u_lw   = {i_half[5], i_half[12:10], i_half[6], 2'b00};
    assign u_ld   = {i_half[6:5], i_half[12:10], 3'b000};
    assign u_16sp = {b12, i_half[4:3], i_half[5], i_half[2], i_half[6], 4'b0000};
    assign u_j    = {b12, i_half[8], i_half[10:9], i_half[6], i_half[7], i_half[2],
                     i_half[11], i_half[5:3], 1'b0};
    assign u_b    = {b12, i_half[6:5], i_half[2], i_half[11:10], i_half[4:3], 1'b0};
    assign u_lwsp = {i_half[3:2], b12, i_half[6:4], 2'b00};
    assign u_ldsp = {i_half[4:2], b12, i_half[6:5], 3'b000};
    assign u_swsp = {i_half[8:7], i_half[12:9], 2'b00};
    assign u_sdsp = {i_half[9:7], i_half[12:10], 3'b000};

    always_comb begin
        o_dec = '0;
        unique case (sel)
            C_ADDI4SPN: begin
                if (u_4spn != 10'd0) begin
                    o_dec = '{M_ADDI, F_I, rp2, R_SP, R_ZERO, {22'd0, u_4spn}};
                end
            end
            C_LW: o_dec = '{M_LW, F_I, rp2, rp7, R_ZERO, {25'd0, u_lw}};
            C_LD: o_dec = '{M_LD, F_I, rp2, rp7, R_ZERO, {24'd0, u_ld}};
            C_SW: o_dec = '{M_SW, F_S, R_ZERO, rp7, rp2, {25'd0, u_lw}};
            C_SD: o_dec = '{M_SD, F_S, R_ZERO, rp7, rp2, {24'd0, u_ld}};
            C_ADDI: o_dec = '{M_ADDI, F_I, r5, r5, R_ZERO, imm6};
            C_ADDIW: begin
                if (r5 != R_ZERO) begin
                    o_dec = '{M_ADDIW, F_I, r5, r5, R_ZERO, imm6};
                end
            end
            C_LI: o_dec = '{M_ADDI, F_I, r5, R_ZERO, R_ZERO, imm6};
            C_LUI: begin
                if (r5 == R_SP) begin
                    if (u_16sp != 10'd0) begin
                        o_dec = '{M_ADDI, F_I, R_SP, R_SP, R_ZERO,
                                  {{22{u_16sp[9]}}, u_16sp}};
                    end
                end else if ({b12, s5} != 6'd0) begin
                    o_dec = '{M_LUI, F_U, r5, R_ZERO, R_ZERO,
                              {{14{b12}}, b12, s5, 12'd0}};
                end
            end
            C_MISC_ALU: begin
                unique case (i_half[11:10])
                    2'd0: o_dec = '{M_SRLI, F_I, rp7, rp7, R_ZERO, sh};
                    2'd1: o_dec = '{M_SRAI, F_I, rp7, rp7, R_ZERO, sh};
                    2'd2: o_dec = '{M_ANDI, F_I, rp7, rp7, R_ZERO, imm6};
                    default: o_dec = '{f_calu({b12, i_half[6:5]}), F_R, rp7, rp7, rp2,
                                       32'd0};
                endcase
            end
            C_J: o_dec = '{M_JAL, F_J, R_ZERO, R_ZERO, R_ZERO, {{20{u_j[11]}}, u_j}};
            C_BEQZ: o_dec = '{M_BEQ, F_B, R_ZERO, rp7, R_ZERO, {{23{u_b[8]}}, u_b}};
            C_BNEZ: o_dec = '{M_BNE, F_B, R_ZERO, rp7, R_ZERO, {{23{u_b[8]}}, u_b}};
            C_SLLI: o_dec = '{M_SLLI, F_I, r5, r5, R_ZERO, sh};
            C_LWSP: begin
                if (r5 != R_ZERO) begin
                    o_dec = '{M_LW, F_I, r5, R_SP, R_ZERO, {24'd0, u_lwsp}};
                end
            end
            C_LDSP: begin
                if (r5 != R_ZERO) begin
                    o_dec = '{M_LD, F_I, r5, R_SP, R_ZERO, {23'd0, u_ldsp}};
                end
            end
            C_JR_MV: begin
                // mv / jr when bit 12 clear, add / jalr / ebreak when set
                if (s5 != R_ZERO) begin
                    o_dec = '{M_ADD, F_R, r5, b12 ? r5 : R_ZERO, s5, 32'd0};
                end else if (r5 != R_ZERO) begin
                    o_dec = '{M_JALR, F_I, b12 ? R_RA : R_ZERO, r5, R_ZERO, 32'd0};
                end else if (b12) begin
                    o_dec.mnem = M_EBREAK;
                end
            end
            C_SWSP: o_dec = '{M_SW, F_S, R_ZERO, R_SP, s5, {24'd0, u_swsp}};
            C_SDSP: o_dec = '{M_SD, F_S, R_ZERO, R_SP, s5, {23'd0, u_sdsp}};
            default: o_dec = '0;
        endcase
    end

endmodule
